[sv/rshp_pkg.sv]
// Shared constants for the ray / sphere hit point pipeline.
// No dependencies; used by the channel interfaces, the multiplier and the top level.
package rshp_pkg;

  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;

  // multiplier digit: bits of the second operand retired per pipeline stage
  localparam int MUL_DIG = 16;

endpackage

[sv/rshp_if.sv]
// Valid/ready channel interfaces for ray input items and hit result items.
// Depends on rshp_pkg for the default coordinate width.
interface rshp_in_if #(
  parameter int COORD_WIDTH = rshp_pkg::DEF_COORD_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic signed [COORD_WIDTH-1:0] dir_x;
  logic signed [COORD_WIDTH-1:0] dir_y;
  logic signed [COORD_WIDTH-1:0] dir_z;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic signed [COORD_WIDTH-1:0] center_z;
  logic        [COORD_WIDTH-2:0] sphere_radius;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           center_x, center_y, center_z, sphere_radius,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           center_x, center_y, center_z, sphere_radius,
    output ready
  );
endinterface

interface rshp_out_if #(
  parameter int COORD_WIDTH = rshp_pkg::DEF_COORD_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic signed [COORD_WIDTH-1:0] ray_param;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic                          saturated;

  modport source (
    output valid, hit, ray_param, point_x, point_y, point_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, hit, ray_param, point_x, point_y, point_z, saturated,
    output ready
  );
endinterface

[sv/rshp_mul.sv]
// Pipelined signed multiplier: sign/magnitude split, one MUL_DIG-bit digit of b per stage.
// Depends on rshp_pkg (MUL_DIG). The input split, each digit and the final sign fix are registered.
module rshp_mul #(
  parameter int AW = 17,
  parameter int BW = 17
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);
  import rshp_pkg::*;

  localparam int NDIG = (BW + MUL_DIG - 1) / MUL_DIG;
  localparam int BP   = NDIG * MUL_DIG;
  localparam int PW   = AW + BW;
  localparam int XW   = AW + MUL_DIG;

  logic [AW-1:0]        ma_c;
  logic [BW-1:0]        mb_c;
  logic [AW-1:0]        ma_q  [NDIG+1];
  logic [BP-1:0]        mb_q  [NDIG+1];
  logic [PW-1:0]        acc_q [NDIG+1];
  logic                 neg_q [NDIG+1];
  logic [XW-1:0]        pp_c  [NDIG];
  logic signed [PW-1:0] p_q;

  always_comb begin
    ma_c = a_i[AW-1] ? AW'(-a_i) : AW'(a_i);
    mb_c = b_i[BW-1] ? BW'(-b_i) : BW'(b_i);
    for (int k = 0; k < NDIG; k++) begin
      pp_c[k] = XW'(ma_q[k]) * XW'(mb_q[k][k*MUL_DIG +: MUL_DIG]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q[0]  <= ma_c;
      mb_q[0]  <= BP'(mb_c);
      neg_q[0] <= a_i[AW-1] ^ b_i[BW-1];
      acc_q[0] <= '0;
      for (int k = 0; k < NDIG; k++) begin
        ma_q[k+1]  <= ma_q[k];
        mb_q[k+1]  <= mb_q[k];
        neg_q[k+1] <= neg_q[k];
        acc_q[k+1] <= acc_q[k] + (PW'(pp_c[k]) << (k * MUL_DIG));
      end
      p_q <= neg_q[NDIG] ? -$signed(acc_q[NDIG]) : $signed(acc_q[NDIG]);
    end
  end

  assign p_o = p_q;

endmodule

[sv/rshp_sqrt.sv]
// Pipelined integer square root, one result bit per stage (floor of the exact root).
// No package dependency. The input and each result bit are registered.
module rshp_sqrt #(
  parameter int SW = 8
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [SW-1:0]   rad_i,
  output logic [SW/2-1:0] root_o
);
  localparam int RW = SW / 2;
  localparam int XW = RW + 4;

  logic [SW-1:0] rad_q   [RW+1];
  logic [RW-1:0] root_q  [RW+1];
  logic [XW-1:0] rem_q   [RW+1];
  logic [XW-1:0] cur_c   [RW];
  logic [XW-1:0] trial_c [RW];

  always_comb begin
    for (int k = 0; k < RW; k++) begin
      cur_c[k]   = {rem_q[k][XW-3:0], rad_q[k][SW-1:SW-2]};
      trial_c[k] = XW'({root_q[k], 2'b01});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0]  <= rad_i;
      root_q[0] <= '0;
      rem_q[0]  <= '0;
      for (int k = 0; k < RW; k++) begin
        rad_q[k+1] <= rad_q[k] << 2;
        if (cur_c[k] >= trial_c[k]) begin
          rem_q[k+1]  <= cur_c[k] - trial_c[k];
          root_q[k+1] <= {root_q[k][RW-2:0], 1'b1};
        end else begin
          rem_q[k+1]  <= cur_c[k];
          root_q[k+1] <= {root_q[k][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[RW];

endmodule

[sv/rshp_div.sv]
// Pipelined restoring unsigned divider, one quotient bit per stage.
// No package dependency. The input and each quotient bit are registered; den_i must be nonzero.
module rshp_div #(
  parameter int NW = 8,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);
  logic [NW-1:0] nq_q  [NW+1];
  logic [DW-1:0] rem_q [NW+1];
  logic [DW-1:0] den_q [NW+1];
  logic [DW:0]   cur_c [NW];
  logic          ge_c  [NW];

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      cur_c[k] = {rem_q[k], nq_q[k][NW-1]};
      ge_c[k]  = cur_c[k] >= {1'b0, den_q[k]};
    end
  end

  // numerator bits shift out the top while quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nq_q[0]  <= num_i;
      rem_q[0] <= '0;
      den_q[0] <= den_i;
      for (int k = 0; k < NW; k++) begin
        den_q[k+1] <= den_q[k];
        nq_q[k+1]  <= {nq_q[k][NW-2:0], ge_c[k]};
        rem_q[k+1] <= ge_c[k] ? DW'(cur_c[k] - {1'b0, den_q[k]}) : DW'(cur_c[k]);
      end
    end
  end

  assign quo_o = nq_q[NW];

endmodule

[sv/rshp_dly.sv]
// Enabled delay line that carries valid bits and side data alongside the arithmetic units.
// No package dependency.
module rshp_dly #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);
  logic [WIDTH-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) sr_q[k] <= '0;
    end else if (en_i) begin
      sr_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) sr_q[k] <= sr_q[k-1];
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

[sv/ray_sphere_hit_point.sv]
// Ray / sphere hit point pipeline; the root and divider stages make up most of its depth.
// Throughput one item per cycle; the whole pipeline holds while the output register stalls.
// Reset (rst_ni low, asynchronous) clears every valid bit; no item is in flight afterwards.
// Depends on rshp_pkg, rshp_if, rshp_mul, rshp_sqrt, rshp_div and rshp_dly.
module ray_sphere_hit_point #(
  parameter int COORD_WIDTH = rshp_pkg::DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = rshp_pkg::DEF_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rshp_in_if.sink     in_i,
  rshp_out_if.source  out_o
);
  import rshp_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int PW = 2 * W + 2;
  localparam int KW = 2 * W + 5;
  localparam int SW = 2 * KW;
  localparam int NW = KW + 2 + FRAC_BITS;
  localparam int QW = NW + 1;
  localparam int LA = (W + 1 + MUL_DIG - 1) / MUL_DIG + 2;
  localparam int LB = (KW + MUL_DIG - 1) / MUL_DIG + 2;
  localparam int LC = KW + 1;
  localparam int LD = NW + 1;
  localparam int LE = (W + MUL_DIG - 1) / MUL_DIG + 2;
  localparam int THRESH_RAW = (1 << FRAC_BITS) / 10000 + 1;
  localparam logic signed [QW-1:0] THRESH_Q = QW'(THRESH_RAW);

  typedef struct packed {
    logic                v;
    logic                hit;
    logic                sat;
    logic                negn;
    logic                negf;
    logic [W-1:0]        t;
    logic [2:0][W-1:0]   o;
    logic [2:0][W-1:0]   d;
  } side_t;

  typedef struct packed {
    logic signed [KW-1:0] a;
    logic signed [KW-1:0] h;
  } ah_t;

  logic pipe_en;
  logic out_valid_q;

  assign pipe_en    = !out_valid_q || out_o.ready;
  assign in_i.ready = pipe_en;

  // ---------------- input register
  logic                v0_q;
  logic signed [W-1:0] o0_q [3];
  logic signed [W-1:0] d0_q [3];
  logic signed [W-1:0] c0_q [3];
  logic [W-2:0]        r0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (pipe_en) begin
      v0_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      o0_q[0] <= in_i.origin_x;
      o0_q[1] <= in_i.origin_y;
      o0_q[2] <= in_i.origin_z;
      d0_q[0] <= in_i.dir_x;
      d0_q[1] <= in_i.dir_y;
      d0_q[2] <= in_i.dir_z;
      c0_q[0] <= in_i.center_x;
      c0_q[1] <= in_i.center_y;
      c0_q[2] <= in_i.center_z;
      r0_q    <= in_i.sphere_radius;
    end
  end

  // ---------------- e = o - c
  side_t             s1_d, s1_q;
  logic signed [W:0] e1_d [3];
  logic signed [W:0] e1_q [3];
  logic [W-2:0]      r1_q;

  always_comb begin
    s1_d   = '0;
    s1_d.v = v0_q;
    for (int i = 0; i < 3; i++) begin
      s1_d.o[i] = o0_q[i];
      s1_d.d[i] = d0_q[i];
      e1_d[i]   = (W+1)'(o0_q[i]) - (W+1)'(c0_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (pipe_en) begin
      s1_q <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) e1_q[i] <= e1_d[i];
      r1_q <= r0_q;
    end
  end

  // ---------------- first products: d.d, d.e, e.e, r.r
  logic signed [W:0]    dw1 [3];
  logic signed [W:0]    rw1;
  logic signed [PW-1:0] pdd [3];
  logic signed [PW-1:0] pde [3];
  logic signed [PW-1:0] pee [3];
  logic signed [PW-1:0] prr;

  assign rw1 = $signed({2'b00, r1_q});

  for (genvar i = 0; i < 3; i++) begin : g_m1
    assign dw1[i] = (W+1)'($signed(s1_q.d[i]));
    rshp_mul #(.AW(W+1), .BW(W+1)) u_dd (
      .clk_i(clk_i), .en_i(pipe_en), .a_i(dw1[i]), .b_i(dw1[i]), .p_o(pdd[i]));
    rshp_mul #(.AW(W+1), .BW(W+1)) u_de (
      .clk_i(clk_i), .en_i(pipe_en), .a_i(dw1[i]), .b_i(e1_q[i]), .p_o(pde[i]));
    rshp_mul #(.AW(W+1), .BW(W+1)) u_ee (
      .clk_i(clk_i), .en_i(pipe_en), .a_i(e1_q[i]), .b_i(e1_q[i]), .p_o(pee[i]));
  end

  rshp_mul #(.AW(W+1), .BW(W+1)) u_rr (
    .clk_i(clk_i), .en_i(pipe_en), .a_i(rw1), .b_i(rw1), .p_o(prr));

  side_t s_a;
  rshp_dly #(.WIDTH($bits(side_t)), .DEPTH(LA)) u_dly_a (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(pipe_en), .d_i(s1_q), .q_o(s_a));

  // ---------------- a = |d|^2, h = d.e (half of b), k = |e|^2 - r^2
  side_t                s2_q;
  ah_t                  ah2_d, ah2_q;
  logic signed [KW-1:0] k2_d, k2_q;

  always_comb begin
    ah2_d.a = KW'(pdd[0]) + KW'(pdd[1]) + KW'(pdd[2]);
    ah2_d.h = KW'(pde[0]) + KW'(pde[1]) + KW'(pde[2]);
    k2_d    = KW'(pee[0]) + KW'(pee[1]) + KW'(pee[2]) - KW'(prr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (pipe_en) begin
      s2_q <= s_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ah2_q <= ah2_d;
      k2_q  <= k2_d;
    end
  end

  // ---------------- h^2 and a*k
  logic signed [2*KW-1:0] phh, pak;

  rshp_mul #(.AW(KW), .BW(KW)) u_hh (
    .clk_i(clk_i), .en_i(pipe_en), .a_i(ah2_q.h), .b_i(ah2_q.h), .p_o(phh));
  rshp_mul #(.AW(KW), .BW(KW)) u_ak (
    .clk_i(clk_i), .en_i(pipe_en), .a_i(ah2_q.a), .b_i(k2_q), .p_o(pak));

  side_t s_b;
  ah_t   ah_b;
  rshp_dly #(.WIDTH($bits(side_t)), .DEPTH(LB)) u_dly_b (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(pipe_en), .d_i(s2_q), .q_o(s_b));
  rshp_dly #(.WIDTH($bits(ah_t)), .DEPTH(LB)) u_dly_ab (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(pipe_en), .d_i(ah2_q), .q_o(ah_b));

  // ---------------- quarter discriminant and hit decision
  logic signed [2*KW:0] dsc_c;
  logic                 hit_c;
  side_t                s3_d, s3_q;
  ah_t                  ah3_q;
  logic [SW-1:0]        rad3_q;

  always_comb begin
    dsc_c    = (2*KW+1)'(phh) - (2*KW+1)'(pak);
    hit_c    = !dsc_c[2*KW] && (dsc_c != '0) && (ah_b.a != '0);
    s3_d     = s_b;
    s3_d.hit = hit_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else if (pipe_en) begin
      s3_q <= s3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ah3_q  <= ah_b;
      rad3_q <= hit_c ? dsc_c[SW-1:0] : '0;
    end
  end

  logic [KW-1:0] root;
  rshp_sqrt #(.SW(SW)) u_sqrt (
    .clk_i(clk_i), .en_i(pipe_en), .rad_i(rad3_q), .root_o(root));

  side_t s_c;
  ah_t   ah_c;
  rshp_dly #(.WIDTH($bits(side_t)), .DEPTH(LC)) u_dly_c (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(pipe_en), .d_i(s3_q), .q_o(s_c));
  rshp_dly #(.WIDTH($bits(ah_t)), .DEPTH(LC)) u_dly_ac (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(pipe_en), .d_i(ah3_q), .q_o(ah_c));

  // ---------------- root numerators (-h -/+ s) scaled by 2^FRAC_BITS
  logic signed [KW+1:0] hx_c, sx_c;
  logic signed [NW-1:0] nn4_d, fn4_d, nn4_q, fn4_q;
  logic signed [KW-1:0] a4_q;
  side_t                s4_q;

  always_comb begin
    hx_c  = (KW+2)'(ah_c.h);
    sx_c  = $signed({2'b00, root});
    nn4_d = NW'(-hx_c - sx_c) << FRAC_BITS;
    fn4_d = NW'(-hx_c + sx_c) << FRAC_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q <= '0;
    end else if (pipe_en) begin
      s4_q <= s_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      nn4_q <= nn4_d;
      fn4_q <= fn4_d;
      a4_q  <= ah_c.a;
    end
  end

  // ---------------- floor division prep: negative n becomes -n + a - 1
  logic [KW-1:0] den5_d, den5_q;
  logic [NW-1:0] mn5_d, mf5_d, mn5_q, mf5_q;
  side_t         s5_d, s5_q;

  always_comb begin
    den5_d    = s4_q.hit ? KW'(a4_q) : KW'(1);
    mn5_d     = nn4_q[NW-1] ? (NW'(~nn4_q) + NW'(den5_d)) : NW'(nn4_q);
    mf5_d     = fn4_q[NW-1] ? (NW'(~fn4_q) + NW'(den5_d)) : NW'(fn4_q);
    s5_d      = s4_q;
    s5_d.negn = nn4_q[NW-1];
    s5_d.negf = fn4_q[NW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_q <= '0;
    end else if (pipe_en) begin
      s5_q <= s5_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      den5_q <= den5_d;
      mn5_q  <= mn5_d;
      mf5_q  <= mf5_d;
    end
  end

  logic [NW-1:0] qn, qf;
  rshp_div #(.NW(NW), .DW(KW)) u_div_near (
    .clk_i(clk_i), .en_i(pipe_en), .num_i(mn5_q), .den_i(den5_q), .quo_o(qn));
  rshp_div #(.NW(NW), .DW(KW)) u_div_far (
    .clk_i(clk_i), .en_i(pipe_en), .num_i(mf5_q), .den_i(den5_q), .quo_o(qf));

  side_t s_d;
  rshp_dly #(.WIDTH($bits(side_t)), .DEPTH(LD)) u_dly_d (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(pipe_en), .d_i(s5_q), .q_o(s_d));

  // ---------------- signed roots, near/far choice, clamp of t
  logic signed [QW-1:0] qn6_d, qf6_d, qn6_q, qf6_q, t7_q;
  side_t                s6_q, s7_q, s8_d, s8_q;
  logic                 tfit_c;

  always_comb begin
    qn6_d = s_d.negn ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
    qf6_d = s_d.negf ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
  end

  always_comb begin
    tfit_c = (t7_q[QW-1:W-1] == {(QW-W+1){t7_q[QW-1]}});
    s8_d   = s7_q;
    if (tfit_c) begin
      s8_d.t = t7_q[W-1:0];
    end else begin
      s8_d.t = t7_q[QW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    s8_d.sat = !tfit_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_q <= '0;
      s7_q <= '0;
      s8_q <= '0;
    end else if (pipe_en) begin
      s6_q <= s_d;
      s7_q <= s6_q;
      s8_q <= s8_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      qn6_q <= qn6_d;
      qf6_q <= qf6_d;
      t7_q  <= (qn6_q >= THRESH_Q) ? qn6_q : qf6_q;
    end
  end

  // ---------------- t * d
  logic signed [2*W-1:0] ptd [3];

  for (genvar i = 0; i < 3; i++) begin : g_m3
    rshp_mul #(.AW(W), .BW(W)) u_td (
      .clk_i(clk_i), .en_i(pipe_en), .a_i($signed(s8_q.t)), .b_i($signed(s8_q.d[i])),
      .p_o(ptd[i]));
  end

  side_t s_e;
  rshp_dly #(.WIDTH($bits(side_t)), .DEPTH(LE)) u_dly_e (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(pipe_en), .d_i(s8_q), .q_o(s_e));

  // ---------------- o + (t*d >>> FRAC_BITS)
  side_t               s9_q;
  logic signed [2*W:0] sum9_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_q <= '0;
    end else if (pipe_en) begin
      s9_q <= s_e;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        sum9_q[i] <= (2*W+1)'($signed(s_e.o[i])) + (2*W+1)'(ptd[i] >>> FRAC_BITS);
      end
    end
  end

  // ---------------- point clamp and output register
  logic [W-1:0] pt_d  [3];
  logic [W-1:0] pt_q  [3];
  logic         pfit_c [3];
  logic         sat_d, sat_q, hit_q;
  logic [W-1:0] t_q;

  always_comb begin
    sat_d = s9_q.sat;
    for (int i = 0; i < 3; i++) begin
      pfit_c[i] = (sum9_q[i][2*W:W-1] == {(W+2){sum9_q[i][2*W]}});
      if (pfit_c[i]) begin
        pt_d[i] = sum9_q[i][W-1:0];
      end else begin
        pt_d[i] = sum9_q[i][2*W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
      if (!pfit_c[i]) sat_d = 1'b1;
      if (!s9_q.hit) pt_d[i] = '0;
    end
    if (!s9_q.hit) sat_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= s9_q.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      hit_q <= s9_q.hit;
      t_q   <= s9_q.hit ? s9_q.t : '0;
      sat_q <= sat_d;
      for (int i = 0; i < 3; i++) pt_q[i] <= pt_d[i];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.hit       = hit_q;
  assign out_o.ray_param = t_q;
  assign out_o.point_x   = pt_q[0];
  assign out_o.point_y   = pt_q[1];
  assign out_o.point_z   = pt_q[2];
  assign out_o.saturated = sat_q;

`ifndef SYNTH
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !hit_q) |-> (t_q == '0 && pt_q[0] == '0 && pt_q[1] == '0 &&
                                 pt_q[2] == '0 && !sat_q))
    else $error("miss result carries nonzero payload");

  a_sat_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && sat_q) |-> hit_q)
    else $error("saturation flagged on a miss");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> ($stable(v0_q) && $stable(s1_q.v) && $stable(s9_q.v) && out_valid_q))
    else $error("pipeline moved during an output stall");
`endif

endmodule
